// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by segment_intersection_test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Property that must hold at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) (prop)) else $error(msg);
`endif

// ----- hw/rtl/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg
// Shared constants and helper functions of the segment intersection test.
// ----------------------------------------------------------------------------
package sit_pkg;
  localparam int CoordBitsDef = 12;

  // Width of a numerator: up to about 4*C+4 bits; denominator up to 2*C+3.
  function automatic int num_bits(input int cb);
    return 4 * cb + 4;
  endfunction

  function automatic int den_bits(input int cb);
    return 2 * cb + 3;
  endfunction
endpackage

// ----- hw/rtl/sit_front.sv -----
// ----------------------------------------------------------------------------
// sit_front
// Computes the denominator and the two numerators, two register stages.
// ----------------------------------------------------------------------------
module sit_front import sit_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int NB = num_bits(COORD_BITS),
  parameter int DB = den_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  input  logic signed [COORD_BITS-1:0] x3,
  input  logic signed [COORD_BITS-1:0] y3,
  input  logic signed [COORD_BITS-1:0] x4,
  input  logic signed [COORD_BITS-1:0] y4,
  output logic signed [NB-1:0]         numx,
  output logic signed [NB-1:0]         numy,
  output logic signed [DB-1:0]         den
);
  localparam int DW = COORD_BITS + 1;
  localparam int CW = 2 * COORD_BITS + 1;
  localparam int PW = CW + DW;

  logic signed [DW-1:0] dxa, dya, dxb, dyb;
  logic signed [CW-1:0] ca, cb;
  logic signed [PW-1:0] p_ca_dxb, p_dxa_cb, p_ca_dyb, p_dya_cb;

  always_ff @(posedge clk) begin
    if (en) begin
      dxa <= DW'(x1) - DW'(x2);
      dya <= DW'(y1) - DW'(y2);
      dxb <= DW'(x3) - DW'(x4);
      dyb <= DW'(y3) - DW'(y4);
      ca  <= CW'(x1) * CW'(y2) - CW'(y1) * CW'(x2);
      cb  <= CW'(x3) * CW'(y4) - CW'(y3) * CW'(x4);
    end
  end

  always_comb begin
    p_ca_dxb = PW'(ca) * PW'(dxb);
    p_dxa_cb = PW'(dxa) * PW'(cb);
    p_ca_dyb = PW'(ca) * PW'(dyb);
    p_dya_cb = PW'(dya) * PW'(cb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den  <= DB'(dxa) * DB'(dyb) - DB'(dya) * DB'(dxb);
      numx <= NB'(p_ca_dxb) - NB'(p_dxa_cb);
      numy <= NB'(p_ca_dyb) - NB'(p_dya_cb);
    end
  end
endmodule

// ----- hw/rtl/sit_cell.sv -----
// ----------------------------------------------------------------------------
// sit_cell
// One restoring divider step for both quotients; hands data to the next cell.
// ----------------------------------------------------------------------------
module sit_cell import sit_pkg::*; #(
  parameter int NB = num_bits(CoordBitsDef),
  parameter int DB = den_bits(CoordBitsDef),
  parameter int SW = 8 * CoordBitsDef + 3,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] nx_in,
  input  logic [NB-1:0] ny_in,
  input  logic [DB:0]   rx_in,
  input  logic [DB:0]   ry_in,
  input  logic [DB-1:0] d_in,
  input  logic [SW-1:0] side_in,
  output logic [NB-1:0] nx_out,
  output logic [NB-1:0] ny_out,
  output logic [DB:0]   rx_out,
  output logic [DB:0]   ry_out,
  output logic [DB-1:0] d_out,
  output logic [SW-1:0] side_out
);
  localparam int BIT = NB - 1 - STEP;
  logic [DB+1:0] tx, ty;
  logic [NB-1:0] qx, qy;

  // The numerator bit just consumed is replaced by the quotient bit.
  always_comb begin
    tx = {rx_in, nx_in[BIT]} - {2'b00, d_in};
    ty = {ry_in, ny_in[BIT]} - {2'b00, d_in};
    qx = nx_in;
    qy = ny_in;
    qx[BIT] = !tx[DB+1];
    qy[BIT] = !ty[DB+1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out    <= d_in;
      side_out <= side_in;
      nx_out   <= qx;
      ny_out   <= qy;
      rx_out <= tx[DB+1] ? {rx_in[DB-1:0], nx_in[BIT]} : tx[DB:0];
      ry_out <= ty[DB+1] ? {ry_in[DB-1:0], ny_in[BIT]} : ty[DB:0];
    end
  end
endmodule

// ----- hw/rtl/segment_intersection_test.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_test
// Pipelined test of whether two line segments cross inside both boxes.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields
// in       input      ax0 ay0 ax1 ay1 bx0 by0 bx1 by1
// out      output     crossing
// One transaction per cycle while the output is not stalled. The chain of
// divider cells computes one quotient bit per cell for both coordinates.
// The whole pipeline advances when the output register is free or taken.
// Reset clears the valid bits only.
module segment_intersection_test import sit_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] ax0,
  input  logic signed [COORD_BITS-1:0] ay0,
  input  logic signed [COORD_BITS-1:0] ax1,
  input  logic signed [COORD_BITS-1:0] ay1,
  input  logic signed [COORD_BITS-1:0] bx0,
  input  logic signed [COORD_BITS-1:0] by0,
  input  logic signed [COORD_BITS-1:0] bx1,
  input  logic signed [COORD_BITS-1:0] by1,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         crossing
);
  `include "assert_macros.svh"
  localparam int NB = num_bits(COORD_BITS);
  localparam int DB = den_bits(COORD_BITS);
  localparam int LAT = NB + 4;
  localparam int CB = COORD_BITS;
  localparam int SB = 8 * CB;

  logic en;
  logic [LAT-1:0] vld;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
      out_valid <= vld[LAT-1];
    end
  end

  // Coordinate delay matching the front stages.
  logic [SB-1:0] c0, c1, c2;
  assign c0 = {ax0, ay0, ax1, ay1, bx0, by0, bx1, by1};
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= c0;
      c2 <= c1;
    end
  end

  logic signed [NB-1:0] numx, numy;
  logic signed [DB-1:0] den;

  sit_front #(.COORD_BITS(COORD_BITS), .NB(NB), .DB(DB)) u_front (
    .clk(clk), .en(en), .x1(ax0), .y1(ay0), .x2(ax1), .y2(ay1),
    .x3(bx0), .y3(by0), .x4(bx1), .y4(by1), .numx(numx), .numy(numy), .den(den)
  );

  // Sign handling: divide magnitudes, fix sign afterwards.
  logic [NB-1:0] mx, my;
  logic [DB-1:0] md;
  logic sx, sy, dz;
  logic [SB-1:0] c3;
  always_ff @(posedge clk) begin
    if (en) begin
      mx <= numx[NB-1] ? NB'(-numx) : NB'(numx);
      my <= numy[NB-1] ? NB'(-numy) : NB'(numy);
      md <= den[DB-1] ? DB'(-den) : DB'(den);
      sx <= numx[NB-1] ^ den[DB-1];
      sy <= numy[NB-1] ^ den[DB-1];
      dz <= (den == '0);
      c3 <= c2;
    end
  end

  // Flags and coordinates ride in side band: side carries {dz,sx,sy,coords}.
  localparam int SW = SB + 3;
  logic [NB-1:0] nx [0:NB];
  logic [NB-1:0] ny [0:NB];
  logic [DB:0]   rx [0:NB];
  logic [DB:0]   ry [0:NB];
  logic [DB-1:0] dd [0:NB];
  logic [SW-1:0] sd [0:NB];
  logic [SW-1:0] sidew;

  assign sidew = {dz, sx, sy, c3};
  assign nx[0] = mx;
  assign ny[0] = my;
  assign rx[0] = '0;
  assign ry[0] = '0;
  assign dd[0] = md;
  assign sd[0] = sidew;

  for (genvar i = 0; i < NB; i++) begin : g_cell
    sit_cell #(.NB(NB), .DB(DB), .SW(SW), .STEP(i)) u_cell (
      .clk(clk), .en(en),
      .nx_in(nx[i]), .ny_in(ny[i]), .rx_in(rx[i]), .ry_in(ry[i]),
      .d_in(dd[i]), .side_in(sd[i]),
      .nx_out(nx[i+1]), .ny_out(ny[i+1]), .rx_out(rx[i+1]), .ry_out(ry[i+1]),
      .d_out(dd[i+1]), .side_out(sd[i+1])
    );
  end

  // Quotients: magnitude is far below NB bits, so signs fit.
  logic [SW-1:0] so;
  logic signed [NB-1:0] px, py;
  logic [SW-1:0] c_q;
  assign so = sd[NB];

  always_ff @(posedge clk) begin
    if (en) begin
      px <= so[SB+1] ? NB'(-nx[NB]) : NB'(nx[NB]);
      py <= so[SB]   ? NB'(-ny[NB]) : NB'(ny[NB]);
      c_q <= so;
    end
  end
  logic signed [CB-1:0] e1, e2, e3, e4, e5, e6, e7, e8;
  assign {e1, e2, e3, e4, e5, e6, e7, e8} = c_q[SB-1:0];

  function automatic logic inb(input logic signed [NB-1:0] v,
                               input logic signed [CB-1:0] a,
                               input logic signed [CB-1:0] b);
    logic signed [NB-1:0] aa, bb;
    aa = NB'(a);
    bb = NB'(b);
    return ((v >= aa) || (v >= bb)) && ((v <= aa) || (v <= bb));
  endfunction

  logic hit;
  assign hit = !c_q[SB+2] && inb(px, e1, e3) && inb(py, e2, e4) &&
               inb(px, e5, e7) && inb(py, e6, e8);

  always_ff @(posedge clk) begin
    if (en) crossing <= hit;
  end

  `ASSERT_IMPL(a_stall_hold, clk, rst, out_valid && !out_ready, ##1 out_valid,
    "result dropped while stalled")
  `ASSERT_IMPL(a_ready, clk, rst, !out_valid, in_ready,
    "not ready with empty output")
  `ASSERT_IMPL(a_rst, clk, rst, $past(rst), !out_valid, "valid after reset")
endmodule
